@@ hw/rtl/cbp_pkg.sv @@
// ----------------------------------------------------------------------------
// cbp_pkg: shared types and constants of the circle boundary projector
// Holds the field widths, the configuration register indexes and the records
// that travel with an item down the square root and divider stages.
// ----------------------------------------------------------------------------
package cbp_pkg;

   // Field widths.
   localparam int COORD_W = 32;
   localparam int RAD_W   = 31;
   localparam int DIFF_W  = 33;
   localparam int SQR_W   = 64;
   localparam int DSQ_W   = 65;
   localparam int ROOT_W  = 33;
   localparam int SREM_W  = 37;
   localparam int NUM_W   = 64;

   // Pipeline depths.
   localparam int SQ_STEPS = 33;
   localparam int DV_STEPS = 64;

   // Configuration register indexes.
   localparam logic [1:0] CSR_CENTER_X      = 2'd0;
   localparam logic [1:0] CSR_CENTER_Y      = 2'd1;
   localparam logic [1:0] CSR_CIRCLE_RADIUS = 2'd2;

   // Item record carried through the square root stages.
   typedef struct packed {
      logic                      moved;
      logic                      zero;
      logic                      neg_x;
      logic                      neg_y;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic [NUM_W-1:0]          num_x;
      logic [NUM_W-1:0]          num_y;
   } sq_side_type;

   // Item record carried through the divider stages.
   typedef struct packed {
      logic                      moved;
      logic                      zero;
      logic                      neg_x;
      logic                      neg_y;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
   } dv_side_type;

endpackage

@@ hw/rtl/cbp_req_if.sv @@
// ----------------------------------------------------------------------------
// cbp_req_if: input item channel of the circle boundary projector
// Valid/ready handshake carrying one particle position and radius.
// ----------------------------------------------------------------------------
interface cbp_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic [30:0]        particle_radius;

   modport source (output valid, output pos_x, output pos_y, output particle_radius,
                   input ready);
   modport sink (input valid, input pos_x, input pos_y, input particle_radius,
                 output ready);
endinterface

@@ hw/rtl/cbp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// cbp_rsp_if: result item channel of the circle boundary projector
// Valid/ready handshake carrying the corrected position and the moved flag.
// ----------------------------------------------------------------------------
interface cbp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic               moved;

   modport source (output valid, output out_x, output out_y, output moved, input ready);
   modport sink (input valid, input out_x, input out_y, input moved, output ready);
endinterface

@@ hw/rtl/cbp_div_lane.sv @@
// ----------------------------------------------------------------------------
// cbp_div_lane: pipelined restoring divider lane
// Loads a 64-bit dividend and a 33-bit divisor, then retires one quotient bit
// per stage. All stages advance together on the enable.
// ----------------------------------------------------------------------------
module cbp_div_lane (
   input  logic                          clock,
   input  logic                          en,
   input  logic [cbp_pkg::NUM_W-1:0]     num_in,
   input  logic [cbp_pkg::ROOT_W-1:0]    dist_in,
   output logic [cbp_pkg::NUM_W-1:0]     quot_out,
   output logic [cbp_pkg::ROOT_W-1:0]    rem_out,
   output logic [cbp_pkg::ROOT_W-1:0]    dist_out
);
   import cbp_pkg::*;

   // Dividend shifts out of the top while quotient bits shift in below.
   logic [NUM_W-1:0]  nq_ff   [0:DV_STEPS];
   logic [ROOT_W-1:0] rem_ff  [0:DV_STEPS];
   logic [ROOT_W-1:0] dist_ff [0:DV_STEPS];

   // Load stage.
   always_ff @(posedge clock) begin
      if (en) begin
         nq_ff[0]   <= num_in;
         rem_ff[0]  <= '0;
         dist_ff[0] <= dist_in;
      end
   end

   // One quotient bit per stage.
   for (genvar k = 0; k < DV_STEPS; k++) begin : g_step
      logic [ROOT_W:0]   remw;
      logic              ge;
      logic [ROOT_W-1:0] rem_in;
      logic [NUM_W-1:0]  nq_in;

      always_comb begin
         remw   = {rem_ff[k], nq_ff[k][NUM_W-1]};
         ge     = (remw >= {1'b0, dist_ff[k]});
         rem_in = ge ? ROOT_W'(remw - {1'b0, dist_ff[k]}) : remw[ROOT_W-1:0];
         nq_in  = {nq_ff[k][NUM_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            nq_ff[k+1]   <= nq_in;
            rem_ff[k+1]  <= rem_in;
            dist_ff[k+1] <= dist_ff[k];
         end
      end
   end

   assign quot_out = nq_ff[DV_STEPS];
   assign rem_out  = rem_ff[DV_STEPS];
   assign dist_out = dist_ff[DV_STEPS];

endmodule

@@ hw/rtl/circle_boundary_projector.sv @@
// Throughput: one item per cycle; the square root (33 stages, one root bit
// each) and the two divider lanes (64 stages, one quotient bit each) are
// fully pipelined. A stall at the output holds every stage in place.
// Reset (synchronous, active high) clears all valid bits and the configuration registers.
// ----------------------------------------------------------------------------
// circle_boundary_projector: keeps a particle inside a configured circle
// Measures the distance from the center, and when it exceeds the allowed
// distance or the allowed distance is negative, places the particle at center + offset * allowed / distance.
// ----------------------------------------------------------------------------
module circle_boundary_projector (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   cbp_req_if.sink     req_if,
   cbp_rsp_if.source   rsp_if
);
   import cbp_pkg::*;

   // Configuration registers.
   logic signed [COORD_W-1:0] center_x_ff;
   logic signed [COORD_W-1:0] center_y_ff;
   logic [RAD_W-1:0]          circle_radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff      <= '0;
         center_y_ff      <= '0;
         circle_radius_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTER_X:      center_x_ff      <= csr_wdata;
            CSR_CENTER_Y:      center_y_ff      <= csr_wdata;
            CSR_CIRCLE_RADIUS: circle_radius_ff <= csr_wdata[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   // Global advance: every stage moves unless a finished item waits.
   logic out_v_ff;
   logic en;
   assign en           = !out_v_ff || rsp_if.ready;
   assign req_if.ready = en;

   // Stage 1: offsets from the center and the allowed distance.
   logic                      s1_v_ff;
   logic signed [DIFF_W-1:0]  s1_dx_ff, s1_dy_ff;
   logic signed [COORD_W-1:0] s1_allowed_ff;
   logic signed [COORD_W-1:0] s1_px_ff, s1_py_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (en) s1_v_ff <= req_if.valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_dx_ff      <= DIFF_W'(req_if.pos_x) - DIFF_W'(center_x_ff);
         s1_dy_ff      <= DIFF_W'(req_if.pos_y) - DIFF_W'(center_y_ff);
         s1_allowed_ff <= $signed({1'b0, circle_radius_ff}) -
                          $signed({1'b0, req_if.particle_radius});
         s1_px_ff      <= req_if.pos_x;
         s1_py_ff      <= req_if.pos_y;
      end
   end

   // Stage 2: squares and scaled numerators from magnitudes.
   logic [COORD_W-1:0] ax, ay, aa;
   always_comb begin
      ax = s1_dx_ff[DIFF_W-1] ? COORD_W'(-s1_dx_ff) : s1_dx_ff[COORD_W-1:0];
      ay = s1_dy_ff[DIFF_W-1] ? COORD_W'(-s1_dy_ff) : s1_dy_ff[COORD_W-1:0];
      aa = s1_allowed_ff[COORD_W-1] ? COORD_W'(-s1_allowed_ff) : s1_allowed_ff;
   end

   logic                      s2_v_ff;
   logic [SQR_W-1:0]          s2_sx_ff, s2_sy_ff, s2_asq_ff;
   logic [NUM_W-1:0]          s2_nx_ff, s2_ny_ff;
   logic                      s2_aneg_ff, s2_negx_ff, s2_negy_ff;
   logic signed [COORD_W-1:0] s2_px_ff, s2_py_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else if (en) s2_v_ff <= s1_v_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_sx_ff   <= SQR_W'(ax) * SQR_W'(ax);
         s2_sy_ff   <= SQR_W'(ay) * SQR_W'(ay);
         s2_asq_ff  <= SQR_W'(aa) * SQR_W'(aa);
         s2_nx_ff   <= NUM_W'(ax) * NUM_W'(aa);
         s2_ny_ff   <= NUM_W'(ay) * NUM_W'(aa);
         s2_aneg_ff <= s1_allowed_ff[COORD_W-1];
         s2_negx_ff <= s1_dx_ff[DIFF_W-1] ^ s1_allowed_ff[COORD_W-1];
         s2_negy_ff <= s1_dy_ff[DIFF_W-1] ^ s1_allowed_ff[COORD_W-1];
         s2_px_ff   <= s1_px_ff;
         s2_py_ff   <= s1_py_ff;
      end
   end

   // Stage 3: squared distance, the boundary test, and the square root seed.
   logic [DSQ_W-1:0] dsq;
   logic             moved_in;
   always_comb begin
      dsq      = {1'b0, s2_sx_ff} + {1'b0, s2_sy_ff};
      moved_in = s2_aneg_ff || (dsq > {1'b0, s2_asq_ff});
   end

   logic              sq_v_ff    [0:SQ_STEPS];
   logic [ROOT_W-1:0] sq_root_ff [0:SQ_STEPS];
   logic [SREM_W-1:0] sq_rem_ff  [0:SQ_STEPS];
   logic [DSQ_W:0]    sq_d_ff    [0:SQ_STEPS];
   sq_side_type       sq_side_ff [0:SQ_STEPS];

   always_ff @(posedge clock) begin
      if (reset) sq_v_ff[0] <= 1'b0;
      else if (en) sq_v_ff[0] <= s2_v_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_root_ff[0]       <= '0;
         sq_rem_ff[0]        <= '0;
         sq_d_ff[0]          <= {1'b0, dsq};
         sq_side_ff[0].moved <= moved_in;
         sq_side_ff[0].zero  <= (dsq == '0);
         sq_side_ff[0].neg_x <= s2_negx_ff;
         sq_side_ff[0].neg_y <= s2_negy_ff;
         sq_side_ff[0].pos_x <= s2_px_ff;
         sq_side_ff[0].pos_y <= s2_py_ff;
         sq_side_ff[0].num_x <= s2_nx_ff;
         sq_side_ff[0].num_y <= s2_ny_ff;
      end
   end

   // Square root: one root bit per stage, two radicand bits consumed.
   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      logic [SREM_W-1:0] remw, trial, rem_in;
      logic [ROOT_W-1:0] root_in;
      logic              ge;

      always_comb begin
         remw    = {sq_rem_ff[k][SREM_W-3:0], sq_d_ff[k][DSQ_W:DSQ_W-1]};
         trial   = {{(SREM_W-ROOT_W-2){1'b0}}, sq_root_ff[k], 2'b01};
         ge      = (remw >= trial);
         rem_in  = ge ? (remw - trial) : remw;
         root_in = {sq_root_ff[k][ROOT_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) sq_v_ff[k+1] <= 1'b0;
         else if (en) sq_v_ff[k+1] <= sq_v_ff[k];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_root_ff[k+1] <= root_in;
            sq_rem_ff[k+1]  <= rem_in;
            sq_d_ff[k+1]    <= {sq_d_ff[k][DSQ_W-2:0], 2'b00};
            sq_side_ff[k+1] <= sq_side_ff[k];
         end
      end
   end

   // Divider lanes share the root as divisor.
   logic [NUM_W-1:0]  quot_x, quot_y;
   logic [ROOT_W-1:0] rem_x, rem_y, dist_x, dist_y;

   cbp_div_lane u_div_x (
      .clock    (clock),
      .en       (en),
      .num_in   (sq_side_ff[SQ_STEPS].num_x),
      .dist_in  (sq_root_ff[SQ_STEPS]),
      .quot_out (quot_x),
      .rem_out  (rem_x),
      .dist_out (dist_x)
   );

   cbp_div_lane u_div_y (
      .clock    (clock),
      .en       (en),
      .num_in   (sq_side_ff[SQ_STEPS].num_y),
      .dist_in  (sq_root_ff[SQ_STEPS]),
      .quot_out (quot_y),
      .rem_out  (rem_y),
      .dist_out (dist_y)
   );

   // Item records alongside the divider stages, load stage included.
   logic        dv_v_ff    [0:DV_STEPS];
   dv_side_type dv_side_ff [0:DV_STEPS];

   always_ff @(posedge clock) begin
      if (reset) dv_v_ff[0] <= 1'b0;
      else if (en) dv_v_ff[0] <= sq_v_ff[SQ_STEPS];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_side_ff[0].moved <= sq_side_ff[SQ_STEPS].moved;
         dv_side_ff[0].zero  <= sq_side_ff[SQ_STEPS].zero;
         dv_side_ff[0].neg_x <= sq_side_ff[SQ_STEPS].neg_x;
         dv_side_ff[0].neg_y <= sq_side_ff[SQ_STEPS].neg_y;
         dv_side_ff[0].pos_x <= sq_side_ff[SQ_STEPS].pos_x;
         dv_side_ff[0].pos_y <= sq_side_ff[SQ_STEPS].pos_y;
      end
   end

   for (genvar k = 0; k < DV_STEPS; k++) begin : g_dvside
      always_ff @(posedge clock) begin
         if (reset) dv_v_ff[k+1] <= 1'b0;
         else if (en) dv_v_ff[k+1] <= dv_v_ff[k];
      end

      always_ff @(posedge clock) begin
         if (en) dv_side_ff[k+1] <= dv_side_ff[k];
      end
   end

   // Final stage: add the signed offset to the center and saturate, or pass the position or the center through.
   localparam int SUM_W = NUM_W + 2;
   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
   localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sd2147483648);

   logic signed [SUM_W-1:0]   sum_x, sum_y, off_x, off_y;
   logic signed [COORD_W-1:0] sat_x, sat_y, res_x, res_y;
   dv_side_type               fin;

   always_comb begin
      fin   = dv_side_ff[DV_STEPS];
      off_x = $signed({2'b00, quot_x});
      off_y = $signed({2'b00, quot_y});
      if (fin.neg_x) off_x = -off_x;
      if (fin.neg_y) off_y = -off_y;
      sum_x = SUM_W'(center_x_ff) + off_x;
      sum_y = SUM_W'(center_y_ff) + off_y;
      if (sum_x > SAT_MAX) sat_x = SAT_MAX[COORD_W-1:0];
      else if (sum_x < SAT_MIN) sat_x = SAT_MIN[COORD_W-1:0];
      else sat_x = sum_x[COORD_W-1:0];
      if (sum_y > SAT_MAX) sat_y = SAT_MAX[COORD_W-1:0];
      else if (sum_y < SAT_MIN) sat_y = SAT_MIN[COORD_W-1:0];
      else sat_y = sum_y[COORD_W-1:0];
      if (!fin.moved) begin
         res_x = fin.pos_x;
         res_y = fin.pos_y;
      end else if (fin.zero) begin
         res_x = center_x_ff;
         res_y = center_y_ff;
      end else begin
         res_x = sat_x;
         res_y = sat_y;
      end
   end

   logic signed [COORD_W-1:0] out_x_ff, out_y_ff;
   logic                      moved_ff;

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (en) out_v_ff <= dv_v_ff[DV_STEPS];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_x_ff <= res_x;
         out_y_ff <= res_y;
         moved_ff <= fin.moved;
      end
   end

   assign rsp_if.valid = out_v_ff;
   assign rsp_if.out_x = out_x_ff;
   assign rsp_if.out_y = out_y_ff;
   assign rsp_if.moved = moved_ff;

   // A zero distance can only be flagged as moved with a negative allowance,
   // which makes both offset signs negative.
   a_zero_moved: assert property (@(posedge clock) disable iff (reset)
      (sq_v_ff[0] && sq_side_ff[0].zero && sq_side_ff[0].moved) |->
      (sq_side_ff[0].neg_x && sq_side_ff[0].neg_y))
      else $error("zero distance flagged moved with nonnegative allowance");

   // A nonzero radicand always yields a nonzero root.
   a_root_nonzero: assert property (@(posedge clock) disable iff (reset)
      (sq_v_ff[SQ_STEPS] && !sq_side_ff[SQ_STEPS].zero) |-> (sq_root_ff[SQ_STEPS] != '0))
      else $error("square root of nonzero distance is zero");

   // Both divider lanes end with a remainder below the divisor.
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (dv_v_ff[DV_STEPS] && !fin.zero) |-> (rem_x < dist_x) && (rem_y < dist_y))
      else $error("divider remainder not below divisor");

   // The output register holds its item while the sink stalls.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_if.ready) |=> out_v_ff && $stable(out_x_ff) && $stable(moved_ff))
      else $error("stalled result changed");

endmodule

@@ tb/circle_boundary_projector_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_boundary_projector_tb: self-checking bench of the circle projector
// Drives particle items through the request channel with random gaps, computes
// the projected position of each one with a predictor of its own and compares
// every result item field by field, across several circle settings.
// ----------------------------------------------------------------------------
module circle_boundary_projector_tb;
   import cbp_pkg::*;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [30:0]        particle_radius;
   } particle_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic               moved;
   } placement_type;

   localparam int WATCHDOG_LIMIT = 20000;

   // Index past the last register; writes to it must be ignored.
   localparam logic [1:0] CSR_NO_REG = 2'd3;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   cbp_req_if req_if ();
   cbp_rsp_if rsp_if ();

   circle_boundary_projector u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_if.sink),
      .rsp_if    (rsp_if.source)
   );

   // Circle settings as the predictor sees them.
   logic signed [31:0] circle_cx;
   logic signed [31:0] circle_cy;
   logic [30:0]        circle_r;

   particle_type  particle_queue[$];
   placement_type placement_queue[$];
   int  mismatch_count;
   int  idle_cycles;
   bit  hold_off;
   bit  calm;
   int  hold_count;

   // Clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Floor of the square root of a 65-bit value, one bit per pass.
   function automatic logic [32:0] floor_root(input logic [64:0] sq);
      logic [32:0]  root;
      logic [65:0]  trial;
      root = '0;
      for (int b = 32; b >= 0; b--) begin
         trial = ({33'd0, root | (33'd1 << b)}) * ({33'd0, root | (33'd1 << b)});
         if (trial <= {1'b0, sq})
            root = root | (33'd1 << b);
      end
      return root;
   endfunction

   // Signed offset scaled by allowed / root_len, truncated toward zero.
   function automatic logic signed [65:0] scale_offset(input logic signed [33:0] d,
                                                       input logic signed [32:0] allowed,
                                                       input logic [32:0] root_len);
      logic [65:0] mag;
      logic [65:0] quo;
      mag = 66'(d < 0 ? -d : d) * 66'(allowed < 0 ? -allowed : allowed);
      quo = mag / 66'(root_len);
      return ((d < 0) != (allowed < 0)) ? -$signed(quo) : $signed(quo);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647)
         return 32'h7fffffff;
      if (v < -66'sd2147483648)
         return 32'h80000000;
      return v[31:0];
   endfunction

   // Projected placement of one particle under the current circle.
   function automatic placement_type project_particle(input particle_type p);
      placement_type      res;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic [64:0]        dsq;
      logic signed [32:0] allowed;
      logic [32:0]        root_len;
      dx = 34'(p.pos_x) - 34'(circle_cx);
      dy = 34'(p.pos_y) - 34'(circle_cy);
      dsq = 65'(66'(dx < 0 ? -dx : dx) * 66'(dx < 0 ? -dx : dx))
          + 65'(66'(dy < 0 ? -dy : dy) * 66'(dy < 0 ? -dy : dy));
      allowed = $signed({2'b00, circle_r}) - $signed({2'b00, p.particle_radius});
      res.out_x = p.pos_x;
      res.out_y = p.pos_y;
      res.moved = (allowed < 0) || (dsq > 65'(66'(allowed) * 66'(allowed)));
      if (res.moved) begin
         if (dsq == 0) begin
            res.out_x = circle_cx;
            res.out_y = circle_cy;
         end else begin
            root_len = floor_root(dsq);
            res.out_x = sat32(66'(circle_cx) + scale_offset(dx, allowed, root_len));
            res.out_y = sat32(66'(circle_cy) + scale_offset(dy, allowed, root_len));
         end
      end
      return res;
   endfunction

   // Intake: predicts each item at the edge where it is accepted.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         placement_queue.push_back(project_particle(particle_queue.pop_front()));
      end
   end

   // Driver: offers the oldest pending item.
   always @(negedge clock) begin
      if (!reset) begin
         if (particle_queue.size() > 0 && (calm || $urandom_range(99) >= 36)) begin
            req_if.valid <= 1'b1;
            {req_if.pos_x, req_if.pos_y, req_if.particle_radius} <= particle_queue[0];
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver readiness, with an occasional long hold-off.
   always @(negedge clock) begin
      if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         rsp_if.ready <= 1'b0;
      end else if (hold_off) begin
         hold_count <= 300;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= calm || $urandom_range(99) >= 36;
      end
   end

   // Monitor: checks each result item against the oldest prediction.
   always @(posedge clock) begin
      placement_type got;
      placement_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.out_x, rsp_if.out_y, rsp_if.moved};
         if (placement_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result x=%h y=%h moved=%b", got.out_x, got.out_y,
                        got.moved);
         end else begin
            want = placement_queue.pop_front();
            if (got != want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected x=%h y=%h moved=%b, got x=%h y=%h moved=%b",
                           want.out_x, want.out_y, want.moved,
                           got.out_x, got.out_y, got.moved);
            end
         end
      end
   end

   // Watchdog on cycles with no accepted item on either channel.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_CENTER_X:      circle_cx = value;
         CSR_CENTER_Y:      circle_cy = value;
         CSR_CIRCLE_RADIUS: circle_r  = value[30:0];
         default: ;
      endcase
   endtask

   // Waits until every item has been taken and every result checked.
   task automatic drain();
      while (particle_queue.size() > 0 || placement_queue.size() > 0 || req_if.valid)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord(input int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
         default: return 32'($signed(circle_cx) + $signed($urandom_range(131072 * 8))
                             - 131072 * 4);
      endcase
   endfunction

   task automatic push_random(input int count);
      particle_type p;
      int mode;
      for (int i = 0; i < count; i++) begin
         mode = $urandom_range(2);
         p.pos_x = rand_coord(mode);
         p.pos_y = rand_coord(mode);
         case ($urandom_range(3))
            0: p.particle_radius = 31'($urandom());
            1: p.particle_radius = '0;
            default: p.particle_radius = 31'($urandom_range(65536 * 4));
         endcase
         particle_queue.push_back(p);
      end
   endtask

   initial begin
      logic [31:0] cxs[5];
      logic [31:0] rads[5];
      cxs = '{32'h0, 32'h80000000, 32'h7fffffff, 32'h00030000, 32'hfffa0000};
      rads = '{32'h0, 32'h7fffffff, 32'h00050000, 32'h00000001, $urandom()};
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.pos_x = '0;
      req_if.pos_y = '0;
      req_if.particle_radius = '0;
      rsp_if.ready = 1'b0;
      circle_cx = '0;
      circle_cy = '0;
      circle_r = '0;
      mismatch_count = 0;
      hold_off = 1'b0;
      hold_count = 0;
      calm = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed items: extremes, particle on the center, negative allowed distance.
      write_reg(CSR_CIRCLE_RADIUS, 32'h00050000);
      particle_queue.push_back('{32'sh0, 32'sh0, 31'h0});
      particle_queue.push_back('{32'sh0, 32'sh0, 31'h00060000});
      particle_queue.push_back('{32'sh00010000, 32'sh00010000, 31'h0});
      particle_queue.push_back('{32'sh00100000, 32'sh0, 31'h0});
      particle_queue.push_back('{32'sh00030000, -32'sh00040000, 31'h0});
      particle_queue.push_back('{32'sh7fffffff, 32'sh7fffffff, 31'h0});
      particle_queue.push_back('{32'sh80000000, 32'sh80000000, 31'h0});
      particle_queue.push_back('{32'sh7fffffff, 32'sh80000000, 31'h7fffffff});
      particle_queue.push_back('{32'sh00100000, -32'sh00200000, 31'h7fffffff});
      particle_queue.push_back('{32'sh00000001, 32'sh0, 31'h00050001});
      particle_queue.push_back('{-32'sh00050000, 32'sh0, 31'h0});
      drain();
      write_reg(CSR_CENTER_X, 32'h7fffffff);
      write_reg(CSR_CENTER_Y, 32'h80000000);
      write_reg(CSR_CIRCLE_RADIUS, 32'h00010000);
      particle_queue.push_back('{32'sh80000000, 32'sh7fffffff, 31'h0});
      particle_queue.push_back('{32'sh7fffffff, 32'sh80000000, 31'h00020000});
      particle_queue.push_back('{32'sh0, 32'sh0, 31'h7fffffff});
      drain();

      // Random phases over several circle settings.
      for (int ph = 0; ph < 10; ph++) begin
         write_reg(CSR_CENTER_X, cxs[ph % 5]);
         write_reg(CSR_CENTER_Y, ph < 5 ? cxs[(ph + 2) % 5] : $urandom());
         write_reg(CSR_CIRCLE_RADIUS, ph < 5 ? rads[ph] : $urandom_range(65536 * 64));
         write_reg(CSR_NO_REG, $urandom());
         calm = (ph == 3);
         push_random(190);
         if (ph == 6) begin
            repeat (20) @(posedge clock);
            hold_off = 1'b1;
            @(posedge clock);
            hold_off = 1'b0;
         end
         drain();
      end

      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

@@ circle_boundary_projector.f @@
hw/rtl/cbp_pkg.sv
hw/rtl/cbp_req_if.sv
hw/rtl/cbp_rsp_if.sv
hw/rtl/cbp_div_lane.sv
hw/rtl/circle_boundary_projector.sv
tb/circle_boundary_projector_tb.sv
